@@ hw/rtl/rta_pkg.sv @@
package rta_pkg;

	localparam int MAX_SOURCES_DEF = 16;
	localparam int ID_WIDTH_DEF    = 8;
	localparam int TIME_WIDTH_DEF  = 32;

	localparam int EXP_W      = 5;
	localparam int TIMEOUT_W  = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 32'd1000;

	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd1;

	localparam logic OP_STATUS = 1'b0;
	localparam logic OP_TIME   = 1'b1;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_UNDEF_ID = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOT_CFG  = 3'd3,
		ST_AWAIT    = 3'd4
	} status_t;

	// per-entry verdict of the shared compare unit
	typedef struct packed {
		logic key_match;
		logic timed_out;
	} entry_res_t;

endpackage

@@ hw/rtl/ready_to_arm_aggregator_top.sv @@
// Ready-to-arm aggregator.
// Input channel (in_valid / in_stall) carries one item: a status report from a
// source keyed by system/subsystem/process id, or a time update that
// evaluates the source table. Every item yields exactly one result item on
// the output channel (out_valid / out_stall).
// An item that needs a table pass goes from S_SCAN to S_FINISH; rejected ids
// and unconfigured or short time items go straight to S_FINISH. The pass reads
// one table entry per cycle through the single read port of the entry RAM and
// feeds the shared key/elapsed compare unit. in_stall is high while an item is
// in work. The next item is taken the cycle after a result is loaded.
// If the receiver stalls, the result holds on the outputs; one more item may
// be accepted and worked, but it is not completed until the result is taken.
// cfg_we writes expected_signals (index 0) or timeout_ticks (index 1); other
// indexes are ignored. Write only while the block is idle.
// Reset (arst_n low) empties the table, clears time and flags, sets
// expected_signals to 0 and timeout_ticks to 1000. No clearing pass is needed.
module ready_to_arm_aggregator_top #(
	parameter int MAX_SOURCES = rta_pkg::MAX_SOURCES_DEF,
	parameter int ID_WIDTH    = rta_pkg::ID_WIDTH_DEF,
	parameter int TIME_WIDTH  = rta_pkg::TIME_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [rta_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [rta_pkg::CFG_DATA_W-1:0]          cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic                                    operation,
	input  logic [ID_WIDTH-1:0]                     system_id,
	input  logic [ID_WIDTH-1:0]                     subsystem_id,
	input  logic [ID_WIDTH-1:0]                     process_id,
	input  logic                                    ready_flag,
	input  logic [TIME_WIDTH-1:0]                   time_now,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [2:0]                              status,
	output logic                                    arm_ready,
	output logic                                    all_rate_ok,
	output logic                                    all_ever_received,
	output logic [$clog2(MAX_SOURCES+1)-1:0]        source_count
);

	localparam int IDX_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
	localparam int CNT_W  = $clog2(MAX_SOURCES + 1);
	localparam int KEY_W  = 3 * ID_WIDTH;
	localparam int ENT_W  = KEY_W + 1 + TIME_WIDTH;
	localparam int CMPC_W = (CNT_W > rta_pkg::EXP_W) ? CNT_W : rta_pkg::EXP_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t                         state_q;
	logic [rta_pkg::EXP_W-1:0]      expected_q;
	logic [rta_pkg::TIMEOUT_W-1:0]  timeout_q;

	logic [MAX_SOURCES-1:0]         valid_q;
	logic [CNT_W-1:0]               count_q;
	logic [TIME_WIDTH-1:0]          time_q;
	logic                           ready_q;
	logic                           rate_ok_q;
	logic                           received_q;

	logic                           op_q;
	logic [KEY_W-1:0]               key_q;
	logic                           rdy_q;
	logic                           scanned_q;
	rta_pkg::status_t               pend_q;
	logic [CNT_W-1:0]               cnt_q;
	logic                           rd_on_s1;
	logic [IDX_W-1:0]               rd_idx_s1;
	logic                           hit_q;
	logic [IDX_W-1:0]               hit_slot_q;
	logic                           free_q;
	logic [IDX_W-1:0]               free_slot_q;
	logic                           all_ready_q;
	logic                           rate_acc_q;

	logic                           out_valid_q;
	rta_pkg::status_t               out_status_q;

	logic                           accept;
	logic                           out_free;
	logic                           finish;
	logic                           id_zero;
	logic                           ram_we;
	logic [IDX_W-1:0]               ram_waddr;
	logic [ENT_W-1:0]               ram_wdata;
	logic [ENT_W-1:0]               ram_rdata;
	logic [KEY_W-1:0]               ent_key;
	logic                           ent_ready;
	logic [TIME_WIDTH-1:0]          ent_stamp;
	logic                           ent_valid;
	rta_pkg::entry_res_t            ent_res;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign finish    = (state_q == S_FINISH) && out_free;
	assign id_zero   = (system_id == '0) || (subsystem_id == '0) || (process_id == '0);

	assign {ent_key, ent_ready, ent_stamp} = ram_rdata;
	assign ent_valid = valid_q[rd_idx_s1];

	assign ram_we    = finish && scanned_q && (op_q == rta_pkg::OP_STATUS) && (hit_q || free_q);
	assign ram_waddr = hit_q ? hit_slot_q : free_slot_q;
	assign ram_wdata = {key_q, rdy_q, time_q};

	rta_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_SOURCES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	rta_entry_unit #(
		.ID_WIDTH   (ID_WIDTH),
		.TIME_WIDTH (TIME_WIDTH)
	) u_entry (
		.key_in    (key_q),
		.key_entry (ent_key),
		.now       (time_q),
		.stamp     (ent_stamp),
		.timeout   (timeout_q),
		.res       (ent_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
			timeout_q  <= rta_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			if (cfg_index == rta_pkg::REG_EXPECTED) begin
				expected_q <= cfg_data[rta_pkg::EXP_W-1:0];
			end else if (cfg_index == rta_pkg::REG_TIMEOUT) begin
				timeout_q <= cfg_data[rta_pkg::TIMEOUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			count_q      <= '0;
			time_q       <= '0;
			ready_q      <= 1'b0;
			rate_ok_q    <= 1'b0;
			received_q   <= 1'b0;
			op_q         <= rta_pkg::OP_STATUS;
			key_q        <= '0;
			rdy_q        <= 1'b0;
			scanned_q    <= 1'b0;
			pend_q       <= rta_pkg::ST_OK;
			cnt_q        <= '0;
			rd_on_s1     <= 1'b0;
			rd_idx_s1    <= '0;
			hit_q        <= 1'b0;
			hit_slot_q   <= '0;
			free_q       <= 1'b0;
			free_slot_q  <= '0;
			all_ready_q  <= 1'b1;
			rate_acc_q   <= 1'b1;
			out_valid_q  <= 1'b0;
			out_status_q <= rta_pkg::ST_OK;
		end else begin
			if (out_valid_q && !out_stall && !finish) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q        <= operation;
						key_q       <= {system_id, subsystem_id, process_id};
						rdy_q       <= ready_flag;
						cnt_q       <= '0;
						rd_on_s1    <= 1'b0;
						hit_q       <= 1'b0;
						free_q      <= 1'b0;
						all_ready_q <= 1'b1;
						rate_acc_q  <= 1'b1;
						if (operation == rta_pkg::OP_STATUS) begin
							if (id_zero) begin
								pend_q    <= rta_pkg::ST_UNDEF_ID;
								scanned_q <= 1'b0;
								state_q   <= S_FINISH;
							end else begin
								scanned_q <= 1'b1;
								state_q   <= S_SCAN;
							end
						end else begin
							time_q <= time_now;
							if (expected_q == '0) begin
								pend_q    <= rta_pkg::ST_NOT_CFG;
								scanned_q <= 1'b0;
								state_q   <= S_FINISH;
							end else if (CMPC_W'(expected_q) > CMPC_W'(count_q)) begin
								pend_q    <= rta_pkg::ST_AWAIT;
								scanned_q <= 1'b0;
								state_q   <= S_FINISH;
							end else begin
								scanned_q <= 1'b1;
								state_q   <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					// address phase, one entry per cycle
					if (cnt_q < CNT_W'(MAX_SOURCES)) begin
						rd_on_s1  <= 1'b1;
						rd_idx_s1 <= cnt_q[IDX_W-1:0];
						cnt_q     <= cnt_q + 1'b1;
					end else begin
						rd_on_s1 <= 1'b0;
					end
					// compare phase on the registered RAM word
					if (rd_on_s1) begin
						if (op_q == rta_pkg::OP_STATUS) begin
							if (ent_valid && ent_res.key_match) begin
								hit_q      <= 1'b1;
								hit_slot_q <= rd_idx_s1;
							end else if (!ent_valid && !free_q) begin
								free_q      <= 1'b1;
								free_slot_q <= rd_idx_s1;
							end
						end else if (ent_valid) begin
							if (!ent_ready) begin
								all_ready_q <= 1'b0;
							end else if (ent_res.timed_out) begin
								all_ready_q <= 1'b0;
								rate_acc_q  <= 1'b0;
							end
						end
					end
					if ((cnt_q == CNT_W'(MAX_SOURCES)) && !rd_on_s1) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (!scanned_q) begin
							out_status_q <= pend_q;
							if (op_q == rta_pkg::OP_TIME) begin
								ready_q <= 1'b0;
							end
						end else if (op_q == rta_pkg::OP_STATUS) begin
							if (hit_q) begin
								out_status_q <= rta_pkg::ST_OK;
							end else if (free_q) begin
								out_status_q         <= rta_pkg::ST_OK;
								valid_q[free_slot_q] <= 1'b1;
								count_q              <= count_q + 1'b1;
							end else begin
								out_status_q <= rta_pkg::ST_FULL;
							end
						end else begin
							out_status_q <= rta_pkg::ST_OK;
							received_q   <= 1'b1;
							rate_ok_q    <= rate_acc_q;
							ready_q      <= all_ready_q;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// flags and count only change when a result is loaded, so they hold while stalled
	assign out_valid         = out_valid_q;
	assign status            = out_status_q;
	assign arm_ready         = ready_q;
	assign all_rate_ok       = rate_ok_q;
	assign all_ever_received = received_q;
	assign source_count      = count_q;

`ifndef NO_ASSERTIONS
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("source count differs from number of valid entries");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= MAX_SOURCES)
		else $error("source count exceeds table size");

	a_ready_implies_flags: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> (rate_ok_q && received_q))
		else $error("ready to arm without rate ok and received");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_status_q)))
		else $error("pending result changed while stalled");
`endif

endmodule

@@ hw/rtl/rta_ram.sv @@
module rta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/rta_entry_unit.sv @@
module rta_entry_unit #(
	parameter int ID_WIDTH   = rta_pkg::ID_WIDTH_DEF,
	parameter int TIME_WIDTH = rta_pkg::TIME_WIDTH_DEF
) (
	input  logic [3*ID_WIDTH-1:0]         key_in,
	input  logic [3*ID_WIDTH-1:0]         key_entry,
	input  logic [TIME_WIDTH-1:0]         now,
	input  logic [TIME_WIDTH-1:0]         stamp,
	input  logic [rta_pkg::TIMEOUT_W-1:0] timeout,
	output rta_pkg::entry_res_t           res
);

	localparam int CMP_W = (TIME_WIDTH > rta_pkg::TIMEOUT_W) ? TIME_WIDTH : rta_pkg::TIMEOUT_W;

	logic [TIME_WIDTH-1:0] elapsed;

	// wrapping tick difference
	assign elapsed       = now - stamp;
	assign res.key_match = (key_in == key_entry);
	assign res.timed_out = (CMP_W'(elapsed) >= CMP_W'(timeout));

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

	localparam int SRC_MAX      = rta_pkg::MAX_SOURCES_DEF;
	localparam int ID_W         = rta_pkg::ID_WIDTH_DEF;
	localparam int TIME_W       = rta_pkg::TIME_WIDTH_DEF;
	localparam int CNT_W        = $clog2(SRC_MAX + 1);
	localparam int KEY_W        = 3 * ID_W;
	localparam int DRAIN_CYCLES = SRC_MAX + 8;
	localparam int HOLD_CYCLES  = 250;

	// indexes that decode to no register
	localparam logic [rta_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [rta_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		rta_pkg::status_t st;
		logic             arm;
		logic             rate;
		logic             heard;
		logic [CNT_W-1:0] count;
	} verdict_t;

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           cfg_we       = 1'b0;
	logic [rta_pkg::CFG_IDX_W-1:0]  cfg_index    = rta_pkg::REG_EXPECTED;
	logic [rta_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
	logic                           in_valid     = 1'b0;
	logic                           in_stall;
	logic                           operation    = rta_pkg::OP_STATUS;
	logic [ID_W-1:0]                system_id    = '0;
	logic [ID_W-1:0]                subsystem_id = '0;
	logic [ID_W-1:0]                process_id   = '0;
	logic                           ready_flag   = 1'b0;
	logic [TIME_W-1:0]              time_now     = '0;
	logic                           out_valid;
	logic                           out_stall    = 1'b0;
	logic [2:0]                     status;
	logic                           arm_ready;
	logic                           all_rate_ok;
	logic                           all_ever_received;
	logic [CNT_W-1:0]               source_count;

	// shadow of the source table and the block's registers
	logic              tbl_valid [SRC_MAX] = '{default: 1'b0};
	logic [KEY_W-1:0]  tbl_key   [SRC_MAX];
	logic              tbl_ready [SRC_MAX];
	logic [TIME_W-1:0] tbl_stamp [SRC_MAX];
	logic [TIME_W-1:0] now_tick    = '0;
	logic              arm_q       = 1'b0;
	logic              rate_q      = 1'b0;
	logic              heard_q     = 1'b0;
	logic [CNT_W-1:0]  src_count   = '0;
	logic [rta_pkg::EXP_W-1:0]     exp_cfg     = '0;
	logic [rta_pkg::TIMEOUT_W-1:0] timeout_cfg = rta_pkg::TIMEOUT_RST;

	verdict_t         pending_verdicts [$];
	logic [KEY_W-1:0] roster [SRC_MAX];
	int               mismatch_count = 0;
	bit               offering       = 1'b0;
	bit               sender_idle    = 1'b1;
	bit               sink_idle      = 1'b1;
	int unsigned      sink_hold      = 0;

	ready_to_arm_aggregator_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.operation         (operation),
		.system_id         (system_id),
		.subsystem_id      (subsystem_id),
		.process_id        (process_id),
		.ready_flag        (ready_flag),
		.time_now          (time_now),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.status            (status),
		.arm_ready         (arm_ready),
		.all_rate_ok       (all_rate_ok),
		.all_ever_received (all_ever_received),
		.source_count      (source_count)
	);

	always #10 clk = ~clk;

	function automatic verdict_t predict_verdict(input logic op, input logic [KEY_W-1:0] key,
			input logic rdy, input logic [TIME_W-1:0] t);
		verdict_t          v;
		int                i;
		int                slot;
		int                free_slot;
		logic              all_ready;
		logic              rate_ok;
		logic [TIME_W-1:0] elapsed;
		v.st = rta_pkg::ST_OK;
		if (op == rta_pkg::OP_STATUS) begin
			if (key[KEY_W-1 -: ID_W] == 0 || key[2*ID_W-1 -: ID_W] == 0 || key[ID_W-1:0] == 0) begin
				v.st = rta_pkg::ST_UNDEF_ID;
			end else begin
				slot = -1;
				free_slot = -1;
				for (i = 0; i < SRC_MAX; i++) begin
					if (tbl_valid[i]) begin
						if (tbl_key[i] == key && slot < 0)
							slot = i;
					end else if (free_slot < 0) begin
						free_slot = i;
					end
				end
				if (slot < 0 && free_slot >= 0) begin
					slot = free_slot;
					tbl_valid[slot] = 1'b1;
					tbl_key[slot] = key;
					src_count++;
				end
				if (slot >= 0) begin
					tbl_ready[slot] = rdy;
					tbl_stamp[slot] = now_tick;
				end else begin
					v.st = rta_pkg::ST_FULL;
				end
			end
		end else begin
			now_tick = t;
			if (exp_cfg == 0) begin
				arm_q = 1'b0;
				v.st = rta_pkg::ST_NOT_CFG;
			end else if (exp_cfg > src_count) begin
				arm_q = 1'b0;
				v.st = rta_pkg::ST_AWAIT;
			end else begin
				all_ready = 1'b1;
				rate_ok = 1'b1;
				for (i = 0; i < SRC_MAX; i++) begin
					if (tbl_valid[i]) begin
						if (!tbl_ready[i]) begin
							all_ready = 1'b0;
						end else begin
							// wraps modulo 2^TIME_W
							elapsed = now_tick - tbl_stamp[i];
							if (elapsed >= timeout_cfg) begin
								all_ready = 1'b0;
								rate_ok = 1'b0;
							end
						end
					end
				end
				heard_q = 1'b1;
				rate_q = rate_ok;
				arm_q = all_ready;
			end
		end
		v.arm = arm_q;
		v.rate = rate_q;
		v.heard = heard_q;
		v.count = src_count;
		return v;
	endfunction

	function automatic logic [KEY_W-1:0] random_key();
		return {ID_W'($urandom_range(1, (1 << ID_W) - 1)),
			ID_W'($urandom_range(1, (1 << ID_W) - 1)),
			ID_W'($urandom_range(1, (1 << ID_W) - 1))};
	endfunction

	function automatic bit on_roster(input logic [KEY_W-1:0] key, input int n);
		int i;
		for (i = 0; i < n; i++)
			if (roster[i] == key)
				return 1'b1;
		return 1'b0;
	endfunction

	// predict on acceptance, check each result against the oldest prediction
	always @(posedge clk) begin
		verdict_t v;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_verdicts.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result with no item pending, status %0d count %0d",
							$realtime, status, source_count);
					mismatch_count++;
				end else begin
					v = pending_verdicts.pop_front();
					if (status !== v.st || arm_ready !== v.arm || all_rate_ok !== v.rate ||
							all_ever_received !== v.heard || source_count !== v.count) begin
						if (mismatch_count < 10)
							$display({"%0t: expected status %0d arm %0b rate_ok %0b received %0b ",
								"count %0d, got %0d %0b %0b %0b %0d"}, $realtime, v.st, v.arm,
								v.rate, v.heard, v.count, status, arm_ready, all_rate_ok,
								all_ever_received, source_count);
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				pending_verdicts.push_back(predict_verdict(operation,
					{system_id, subsystem_id, process_id}, ready_flag, time_now));
		end
	end

	// result side: random stall per item, plus a long hold-off on request
	initial begin
		int unsigned pause;
		forever begin
			pause = sink_idle ? $urandom_range(0, 9) : 0;
			if (sink_hold != 0) begin
				pause = sink_hold;
				sink_hold = 0;
			end
			if (pause != 0) begin
				out_stall <= 1'b1;
				repeat (pause) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_item(input logic op, input logic [KEY_W-1:0] key, input logic rdy,
			input logic [TIME_W-1:0] t);
		int unsigned gap;
		gap = sender_idle ? $urandom_range(0, 9) : 0;
		if (gap != 0) begin
			if (offering)
				in_valid <= 1'b0;
			offering = 1'b0;
			repeat (gap) @(posedge clk);
		end
		operation <= op;
		system_id <= key[KEY_W-1 -: ID_W];
		subsystem_id <= key[2*ID_W-1 -: ID_W];
		process_id <= key[ID_W-1:0];
		ready_flag <= rdy;
		time_now <= t;
		in_valid <= 1'b1;
		offering = 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_idle();
		if (offering)
			in_valid <= 1'b0;
		offering = 1'b0;
		// let the monitor record an item taken at this edge
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rta_pkg::CFG_IDX_W-1:0] idx,
			input logic [rta_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == rta_pkg::REG_EXPECTED)
			exp_cfg = val[rta_pkg::EXP_W-1:0];
		else if (idx == rta_pkg::REG_TIMEOUT)
			timeout_cfg = val[rta_pkg::TIMEOUT_W-1:0];
		@(posedge clk);
	endtask

	task automatic set_config(input logic [rta_pkg::EXP_W-1:0] expected,
			input logic [rta_pkg::TIMEOUT_W-1:0] tmo);
		wait_idle();
		write_reg(rta_pkg::REG_EXPECTED, rta_pkg::CFG_DATA_W'(expected));
		write_reg(rta_pkg::REG_TIMEOUT, rta_pkg::CFG_DATA_W'(tmo));
	endtask

	task automatic test_unconfigured();
		send_item(rta_pkg::OP_TIME, '0, 1'b1, '0);
		send_item(rta_pkg::OP_TIME, '0, 1'b0, '1);
		send_item(rta_pkg::OP_STATUS, 24'h00_5A_A5, 1'b1, '0);
		send_item(rta_pkg::OP_STATUS, 24'hFF_00_FF, 1'b1, '1);
		send_item(rta_pkg::OP_STATUS, 24'h81_7E_00, 1'b0, '0);
		send_item(rta_pkg::OP_STATUS, '0, 1'b1, '0);
		// writes to unused indexes must leave both registers alone
		wait_idle();
		write_reg(REG_SPARE_A, 32'd1);
		write_reg(REG_SPARE_B, '1);
		send_item(rta_pkg::OP_TIME, '0, 1'b1, 32'd40);
		wait_idle();
	endtask

	task automatic test_arm_decision();
		roster[0] = 24'hFF_FF_FF;
		roster[1] = 24'h01_01_01;
		set_config(5'd2, 32'd1000);
		send_item(rta_pkg::OP_TIME, '0, 1'b0, 32'd100);
		send_item(rta_pkg::OP_STATUS, roster[0], 1'b1, '0);
		send_item(rta_pkg::OP_TIME, '0, 1'b0, 32'd200);       // one source short
		send_item(rta_pkg::OP_STATUS, roster[1], 1'b0, '1);
		send_item(rta_pkg::OP_TIME, '0, 1'b1, 32'd300);       // a source not ready
		send_item(rta_pkg::OP_STATUS, roster[1], 1'b1, '0);
		send_item(rta_pkg::OP_TIME, '0, 1'b0, 32'd1099);      // one tick short of timeout
		send_item(rta_pkg::OP_TIME, '0, 1'b0, 32'd1100);      // exactly at timeout
		send_item(rta_pkg::OP_TIME, '0, 1'b0, 32'hFFFF_FF00);
		send_item(rta_pkg::OP_STATUS, roster[0], 1'b1, '0);
		send_item(rta_pkg::OP_STATUS, roster[1], 1'b1, '0);
		send_item(rta_pkg::OP_TIME, '0, 1'b0, 32'h0000_0100); // elapsed wraps through zero
		set_config(5'd2, '0);                                  // every ready source times out
		send_item(rta_pkg::OP_TIME, '0, 1'b0, 32'h0000_0100);
		set_config(5'd1, '1);                                  // more sources than expected
		send_item(rta_pkg::OP_TIME, '0, 1'b0, 32'h0000_0180);
		wait_idle();
	endtask

	task automatic test_table_full();
		int               i;
		logic [KEY_W-1:0] k;
		for (i = 2; i < SRC_MAX; i++) begin
			do k = random_key(); while (on_roster(k, i));
			roster[i] = k;
		end
		set_config(5'(SRC_MAX), 32'd5000);
		for (i = 2; i < SRC_MAX; i++)
			send_item(rta_pkg::OP_STATUS, roster[i], 1'($urandom_range(0, 1)), $urandom);
		do k = random_key(); while (on_roster(k, SRC_MAX));
		send_item(rta_pkg::OP_STATUS, k, 1'b1, $urandom);
		send_item(rta_pkg::OP_STATUS, roster[3], 1'b1, $urandom);
		send_item(rta_pkg::OP_TIME, '0, 1'b1, 32'd4000);
		wait_idle();
	endtask

	task automatic test_backpressure();
		int i;
		sender_idle = 1'b0;
		sink_hold = HOLD_CYCLES;
		for (i = 0; i < 24; i++)
			send_item(1'($urandom_range(0, 1)), roster[$urandom_range(0, SRC_MAX - 1)],
				1'($urandom_range(0, 1)), $urandom);
		wait_idle();
		sender_idle = 1'b1;
	endtask

	task automatic test_random_traffic();
		int                            phase;
		int                            sent;
		int                            i;
		int                            first;
		logic [rta_pkg::EXP_W-1:0]     expected;
		logic [rta_pkg::TIMEOUT_W-1:0] tmo;
		logic [TIME_W-1:0]             t0;
		logic [TIME_W-1:0]             delta;
		logic [KEY_W-1:0]              k;
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin expected = 5'(SRC_MAX); tmo = $urandom_range(50, 5000); end
				1: begin expected = '0; tmo = 32'd1; end
				2: begin expected = 5'd1; tmo = '1; end
				3: begin expected = 5'(SRC_MAX); tmo = 32'd1; end
				default: begin expected = 5'($urandom_range(1, SRC_MAX)); tmo = $urandom; end
			endcase
			set_config(expected, tmo);
			sender_idle = (phase != 0) && ($urandom_range(0, 3) != 0);
			sink_idle = (phase != 0) && ($urandom_range(0, 3) != 0);
			sent = 0;
			while (sent < 200) begin
				if ($urandom_range(0, 9) < 7) begin
					// refresh the sources, then evaluate, often at or near the timeout edge
					t0 = $urandom;
					send_item(rta_pkg::OP_TIME, random_key(), 1'($urandom_range(0, 1)), t0);
					first = $urandom_range(0, SRC_MAX - 1);
					for (i = 0; i < SRC_MAX; i++)
						if ($urandom_range(0, 15) != 0) begin
							send_item(rta_pkg::OP_STATUS, roster[(first + i) % SRC_MAX],
								1'($urandom_range(0, 15) != 0), $urandom);
							sent++;
						end
					case ($urandom_range(0, 4))
						0: delta = '0;
						1: delta = tmo - 1;
						2: delta = tmo;
						3: delta = $urandom_range(0, tmo);
						default: delta = $urandom;
					endcase
					send_item(rta_pkg::OP_TIME, random_key(), 1'($urandom_range(0, 1)),
						t0 + delta);
					sent += 2;
				end else begin
					for (i = 0; i < 5; i++) begin
						k = KEY_W'($urandom);
						if ($urandom_range(0, 2) == 0)
							k = roster[$urandom_range(0, SRC_MAX - 1)];
						else if ($urandom_range(0, 2) == 0)
							k[ID_W * $urandom_range(0, 2) +: ID_W] = '0;
						send_item(1'($urandom_range(0, 1)), k, 1'($urandom_range(0, 1)), $urandom);
					end
					sent += 5;
				end
			end
		end
		wait_idle();
		sender_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unconfigured();
		test_arm_decision();
		test_table_full();
		test_backpressure();
		test_random_traffic();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
